// ===== rtl/wmr_pkg.sv =====
// Shared types and constants of the Weyl mix random generator.
`default_nettype none

package wmr_pkg;

    localparam int unsigned WordW = 64;
    localparam int unsigned HalfW = 32;
    localparam int unsigned SkipW = 31;
    localparam int unsigned CmdW  = 3;
    localparam int unsigned SpanW = HalfW + 1;
    localparam int unsigned StepW = 6;
    localparam int unsigned BitW  = 5;
    localparam int unsigned AddrW = 4;

    localparam logic [WordW-1:0] WeylInc = 64'h0000_0000_e120_fc15;
    localparam logic [HalfW-1:0] MixK1   = 32'h4a39_b70d;
    localparam logic [HalfW-1:0] MixK2   = 32'h12fa_d5c9;

    localparam logic [CmdW-1:0] CMD_RAW    = 3'd0;
    localparam logic [CmdW-1:0] CMD_RANGE  = 3'd1;
    localparam logic [CmdW-1:0] CMD_SIGN   = 3'd2;
    localparam logic [CmdW-1:0] CMD_SKIP   = 3'd3;
    localparam logic [CmdW-1:0] CMD_RESEED = 3'd4;

    localparam logic [AddrW-1:0] REG_SEED = 4'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADV,
        S_MUL,
        S_FOLD,
        S_DIV,
        S_SKIP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

`default_nettype wire

// ===== rtl/wmr_remainder.sv =====
// Restoring bit-serial remainder of a 64-bit dividend by a 33-bit divisor.
`default_nettype none

module wmr_remainder (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [wmr_pkg::WordW-1:0]   i_dividend,
    input  wire logic [wmr_pkg::SpanW-1:0]   i_divisor,
    output logic      [wmr_pkg::HalfW-1:0]   o_rem,
    output wmr_pkg::t_div_sts                o_sts
);
    import wmr_pkg::*;

    logic [WordW-1:0] r_dvd;
    logic [SpanW-1:0] r_dsr;
    logic [HalfW-1:0] r_rem;
    logic [StepW-1:0] r_step;
    logic             r_busy;
    logic             r_done;

    logic [SpanW-1:0] w_trial;
    logic [SpanW-1:0] w_diff;
    logic             w_ge;
    logic [HalfW-1:0] n_rem;

    assign w_trial = {r_rem, r_dvd[WordW-1]};
    assign w_ge    = (w_trial >= r_dsr);
    assign w_diff  = w_trial - r_dsr;
    assign n_rem   = w_ge ? w_diff[HalfW-1:0] : w_trial[HalfW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == {StepW{1'b1}}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[WordW-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rem       = r_rem;
    assign o_sts.busy  = r_busy;
    assign o_sts.done  = r_done;

endmodule

`default_nettype wire

// ===== rtl/weyl_mix_random_generator.sv =====
// Top level of the Weyl mix random generator: command sequencer, serial mixer, skip.
//
//  channel  | dir | tdata (low bit up)                         | tuser
//  s_axis   | in  | range_low[31:0] range_high[31:0] skip[30:0]| cmd[2:0]
//  m_axis   | out | raw_value[63:0] bounded_value[31:0]        | range_error
//  apb      | cfg | reg 0 at byte 0: seed_value[63:0]          | -
//
// Raw and sign draws run two 32-step shift-add multiplies.
// Range draws add a pass of the bit-serial remainder unit unless the range is in error.
// Skip takes a skip_count bit per cycle up to its highest set bit; reseed loads the seed.
// Reset clears the counter, the seed and the result slot; no clearing pass.
// A held result stalls the sequencer only when the next result is ready to be stored.
`default_nettype none

module weyl_mix_random_generator (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // range_low[31:0], range_high[63:32], skip_count[94:64], zero pad[95]
    input  wire logic [95:0]                 s_axis_tdata,
    // cmd[2:0]
    input  wire logic [wmr_pkg::CmdW-1:0]    s_axis_tuser,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // raw_value[63:0], bounded_value[95:64]
    output logic      [95:0]                 m_axis_tdata,
    // range_error[0]
    output logic                             m_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [wmr_pkg::AddrW-1:0]   paddr,
    input  wire logic [wmr_pkg::WordW-1:0]   pwdata,
    output logic      [wmr_pkg::WordW-1:0]   prdata,
    output logic                             pready
);
    import wmr_pkg::*;

    t_state             r_state, n_state;
    logic [CmdW-1:0]    r_cmd;
    logic [HalfW-1:0]   r_lo;
    logic [SpanW-1:0]   r_span;
    logic               r_err;
    logic [SkipW-1:0]   r_skip;
    logic [WordW-1:0]   r_cnt;
    logic [WordW-1:0]   r_seed;
    logic [WordW-1:0]   r_mcand;
    logic [WordW-1:0]   r_acc;
    logic [BitW-1:0]    r_bit;
    logic               r_round;
    logic [WordW-1:0]   r_raw;
    logic [HalfW-1:0]   r_bounded;

    logic               r_out_valid;
    logic [WordW-1:0]   r_out_raw;
    logic [HalfW-1:0]   r_out_bnd;
    logic               r_out_err;

    logic               w_in_acc;
    logic               w_load_out;
    logic               w_div_start;
    logic [CmdW-1:0]    w_cmd;
    logic [HalfW-1:0]   w_lo;
    logic [HalfW-1:0]   w_hi;
    logic [SkipW-1:0]   w_skip;
    logic [HalfW-1:0]   w_mul_k;
    logic [WordW-1:0]   w_fold;
    logic [WordW-1:0]   w_cnt_inc;
    logic [HalfW-1:0]   w_rem;
    t_div_sts           w_div_sts;
    logic               w_cfg_wr;

    assign w_cmd     = s_axis_tuser;
    assign w_lo      = s_axis_tdata[31:0];
    assign w_hi      = s_axis_tdata[63:32];
    assign w_skip    = s_axis_tdata[94:64];
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_mul_k   = r_round ? MixK2 : MixK1;
    assign w_fold    = r_acc ^ (r_acc >> HalfW);
    assign w_cnt_inc = r_cnt + WeylInc;

    // APB
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[3] == REG_SEED[3]);
    assign prdata   = (paddr[3] == REG_SEED[3]) ? r_seed : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (w_cfg_wr) begin
            r_seed <= pwdata;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    priority case (w_cmd)
                        CMD_RAW, CMD_RANGE, CMD_SIGN: n_state = S_ADV;
                        CMD_SKIP: n_state = (w_skip != '0) ? S_SKIP : S_IDLE;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_ADV:  n_state = S_MUL;
            S_MUL:  n_state = (r_bit == {BitW{1'b1}}) ? S_FOLD : S_MUL;
            S_FOLD: begin
                if (!r_round) begin
                    n_state = S_MUL;
                end else if (w_div_start) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV:  n_state = w_div_sts.done ? S_DONE : S_DIV;
            S_SKIP: n_state = (r_skip[SkipW-1:1] == '0) ? S_IDLE : S_SKIP;
            S_DONE: n_state = w_load_out ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        w_load_out    = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
        w_div_start   = (r_state == S_FOLD) && r_round && (r_cmd == CMD_RANGE) && !r_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_acc && (w_cmd == CMD_RESEED)) begin
                r_cnt <= r_seed;
            end else if (r_state == S_ADV) begin
                r_cnt <= w_cnt_inc;
            end else if (r_state == S_SKIP) begin
                r_cnt <= r_cnt + (r_skip[0] ? r_mcand : '0);
            end
        end
    end

    // serial datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_cmd   <= w_cmd;
                    r_lo    <= w_lo;
                    r_err   <= ($signed(w_hi) < $signed(w_lo));
                    r_span  <= {w_hi[HalfW-1], w_hi} - {w_lo[HalfW-1], w_lo}
                               + {{(SpanW-1){1'b0}}, 1'b1};
                    r_skip  <= w_skip;
                    r_mcand <= WeylInc;
                end
            end
            S_ADV: begin
                r_mcand <= w_cnt_inc;
                r_acc   <= '0;
                r_bit   <= '0;
                r_round <= 1'b0;
            end
            S_MUL: begin
                r_acc   <= r_acc + (w_mul_k[r_bit] ? r_mcand : '0);
                r_mcand <= {r_mcand[WordW-2:0], 1'b0};
                r_bit   <= r_bit + 1'b1;
            end
            S_FOLD: begin
                if (!r_round) begin
                    r_mcand <= w_fold;
                    r_acc   <= '0;
                    r_round <= 1'b1;
                end else begin
                    r_raw <= w_fold;
                    priority case (r_cmd)
                        CMD_RAW:   r_bounded <= w_fold[HalfW-1:0];
                        CMD_SIGN:  r_bounded <= w_fold[0] ? {HalfW{1'b1}}
                                                          : {{(HalfW-1){1'b0}}, 1'b1};
                        default:   r_bounded <= '0;
                    endcase
                end
            end
            S_DIV: begin
                if (w_div_sts.done) begin
                    r_bounded <= r_lo + w_rem;
                end
            end
            S_SKIP: begin
                r_mcand <= {r_mcand[WordW-2:0], 1'b0};
                r_skip  <= r_skip >> 1;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    wmr_remainder u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_fold),
        .i_divisor  (r_span),
        .o_rem      (w_rem),
        .o_sts      (w_div_sts)
    );

    // result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_raw <= r_raw;
            r_out_bnd <= r_bounded;
            r_out_err <= (r_cmd == CMD_RANGE) && r_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_bnd, r_out_raw};
    assign m_axis_tuser  = r_out_err;

    // checks
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> (r_state == S_DIV))
        else $error("remainder finished outside its wait state");

    a_reseed_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (w_cmd == CMD_RESEED)) |=> (r_cnt == $past(r_seed)))
        else $error("reseed request did not load the counter");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[95:64] == '0))
        else $error("range error result with nonzero bounded value");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && r_out_valid && !m_axis_tready) |=> (r_state == S_DONE))
        else $error("result slot overwritten while held");

endmodule

`default_nettype wire
